// File: rtl/core/drt_pkg.sv
// Package for the deferred release table: table geometry, action codes,
// item and result structs, and the controller/datapath command bundles.
// No dependencies.
package drt_pkg;

    // table geometry
    localparam int TableDepth = 16;
    localparam int IdxW       = $clog2(TableDepth);
    localparam int OccW       = $clog2(TableDepth + 1);

    // field widths fixed by the interface
    localparam int ActionW = 3;
    localparam int HandleW = 16;
    localparam int DelayW  = 8;
    localparam int CountW  = 5;

    // action codes
    localparam logic [ActionW-1:0] ACT_INSERT        = 3'd0;
    localparam logic [ActionW-1:0] ACT_TICK          = 3'd1;
    localparam logic [ActionW-1:0] ACT_RELEASE_ONE   = 3'd2;
    localparam logic [ActionW-1:0] ACT_RELEASE_READY = 3'd3;
    localparam logic [ActionW-1:0] ACT_RELEASE_ALL   = 3'd4;

    typedef struct packed {
        logic [ActionW-1:0] action;
        logic [HandleW-1:0] handle;
        logic [DelayW-1:0]  frame_delay;
    } t_item;

    typedef struct packed {
        logic [HandleW-1:0] released_handle;
        logic               handle_valid;
        logic               rejected;
        logic [CountW-1:0]  pending_count;
        logic [CountW-1:0]  ready_count;
        logic               last;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic insert;    // append the incoming item and report
        logic status;    // report current counts, no handle
        logic clr_idx;   // restart the slot walk at slot zero
        logic tick;      // decrement one countdown, step the walk
        logic advance;   // step the release scan
        logic free_slot; // release the slot under the scan
        logic move;      // move the last entry into the freed slot
        logic all_step;  // report one slot of a release-all
        logic single;    // the current item is a release-one
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic occ_zero;
        logic ready_zero;
        logic idx_last;
        logic cur_zero;
    } t_sts;

endpackage

// File: rtl/core/drt_ctrl.sv
// Controller for the deferred release table: sequences the slot walks
// for frame tick, release and release-all. Depends on drt_pkg.
module drt_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [drt_pkg::ActionW-1:0] i_action,
    input  drt_pkg::t_sts               i_sts,
    output drt_pkg::t_cmd               o_cmd,
    output logic                        busy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TICK = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_ALL  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_single, n_single;

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_single = r_single;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_single = (i_action == drt_pkg::ACT_RELEASE_ONE);
                    unique case (i_action) inside
                        drt_pkg::ACT_INSERT: begin
                            o_cmd.insert = 1'b1;
                        end
                        drt_pkg::ACT_TICK: begin
                            if (i_sts.occ_zero) begin
                                o_cmd.status = 1'b1;
                            end else begin
                                o_cmd.clr_idx = 1'b1;
                                n_state = S_TICK;
                            end
                        end
                        drt_pkg::ACT_RELEASE_ONE, drt_pkg::ACT_RELEASE_READY: begin
                            if (i_sts.ready_zero) begin
                                o_cmd.status = 1'b1;
                            end else begin
                                o_cmd.clr_idx = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        drt_pkg::ACT_RELEASE_ALL: begin
                            if (i_sts.occ_zero) begin
                                o_cmd.status = 1'b1;
                            end else begin
                                o_cmd.clr_idx = 1'b1;
                                n_state = S_ALL;
                            end
                        end
                        default: begin
                            o_cmd.status = 1'b1;
                        end
                    endcase
                end
            end
            S_TICK: begin
                o_cmd.tick = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                // a ready entry is known to exist, so the scan always hits
                if (i_sts.cur_zero) begin
                    o_cmd.free_slot = 1'b1;
                    n_state = S_MOVE;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_MOVE: begin
                // resume the scan at the refilled slot
                o_cmd.move = 1'b1;
                if (r_single || i_sts.ready_zero) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_ALL: begin
                o_cmd.all_step = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.single = r_single;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_single <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_single <= n_single;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// File: rtl/core/drt_datapath.sv
// Datapath for the deferred release table: slot storage, entry and ready
// counters, walk index and the registered result. Depends on drt_pkg.
module drt_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  drt_pkg::t_item   i_item,
    input  drt_pkg::t_cmd    i_cmd,
    output drt_pkg::t_sts    o_sts,
    output drt_pkg::t_result o_result,
    output logic             o_strobe
);

    localparam int IdxW = drt_pkg::IdxW;
    localparam int OccW = drt_pkg::OccW;

    logic [drt_pkg::HandleW-1:0] r_hdl [drt_pkg::TableDepth];
    logic [drt_pkg::DelayW-1:0]  r_cnt [drt_pkg::TableDepth];

    logic [OccW-1:0] r_occ, n_occ;
    logic [OccW-1:0] r_ready, n_ready;
    logic [IdxW-1:0] r_idx, n_idx;

    drt_pkg::t_result r_res, n_res;
    logic             r_strobe, n_strobe;

    logic [IdxW-1:0]             rd_addr;
    logic [drt_pkg::HandleW-1:0] rd_hdl;
    logic [drt_pkg::DelayW-1:0]  rd_cnt;
    logic                        rd_zero;

    logic                        wr_hdl_en;
    logic                        wr_cnt_en;
    logic [IdxW-1:0]             wr_addr;
    logic [drt_pkg::HandleW-1:0] wr_hdl;
    logic [drt_pkg::DelayW-1:0]  wr_cnt;

    logic full;
    logic idx_last;

    // single read port: the last slot during a move, the walk index otherwise
    assign rd_addr = i_cmd.move ? r_occ[IdxW-1:0] : r_idx;
    assign rd_hdl  = r_hdl[rd_addr];
    assign rd_cnt  = r_cnt[rd_addr];
    assign rd_zero = (rd_cnt == '0);

    assign full     = (r_occ == OccW'(drt_pkg::TableDepth));
    assign idx_last = ((OccW'(r_idx) + OccW'(1)) == r_occ);

    assign o_sts.occ_zero   = (r_occ == '0);
    assign o_sts.ready_zero = (r_ready == '0);
    assign o_sts.idx_last   = idx_last;
    assign o_sts.cur_zero   = rd_zero;

    // update counters, slots and result
    always_comb begin
        n_occ     = r_occ;
        n_ready   = r_ready;
        n_idx     = r_idx;
        n_res     = '0;
        n_strobe  = 1'b0;
        wr_hdl_en = 1'b0;
        wr_cnt_en = 1'b0;
        wr_addr   = r_idx;
        wr_hdl    = rd_hdl;
        wr_cnt    = rd_cnt;

        if (i_cmd.clr_idx) begin
            n_idx = '0;
        end

        if (i_cmd.insert) begin
            if (!full) begin
                wr_hdl_en = 1'b1;
                wr_cnt_en = 1'b1;
                wr_addr   = r_occ[IdxW-1:0];
                wr_hdl    = i_item.handle;
                wr_cnt    = i_item.frame_delay;
                n_occ     = r_occ + OccW'(1);
                if (i_item.frame_delay == '0) begin
                    n_ready = r_ready + OccW'(1);
                end
            end
            n_strobe          = 1'b1;
            n_res.rejected    = full;
            n_res.last        = 1'b1;
            n_res.pending_count = drt_pkg::CountW'(n_occ);
            n_res.ready_count   = drt_pkg::CountW'(n_ready);
        end

        if (i_cmd.status) begin
            n_strobe            = 1'b1;
            n_res.last          = 1'b1;
            n_res.pending_count = drt_pkg::CountW'(r_occ);
            n_res.ready_count   = drt_pkg::CountW'(r_ready);
        end

        // frame tick: one slot per cycle, report after the last slot
        if (i_cmd.tick) begin
            if (!rd_zero) begin
                wr_cnt_en = 1'b1;
                wr_cnt    = rd_cnt - drt_pkg::DelayW'(1);
                if (rd_cnt == drt_pkg::DelayW'(1)) begin
                    n_ready = r_ready + OccW'(1);
                end
            end
            n_idx = r_idx + IdxW'(1);
            if (idx_last) begin
                n_strobe            = 1'b1;
                n_res.last          = 1'b1;
                n_res.pending_count = drt_pkg::CountW'(r_occ);
                n_res.ready_count   = drt_pkg::CountW'(n_ready);
            end
        end

        if (i_cmd.advance) begin
            n_idx = r_idx + IdxW'(1);
        end

        // release the ready slot under the scan
        if (i_cmd.free_slot) begin
            n_occ                 = r_occ - OccW'(1);
            n_ready               = r_ready - OccW'(1);
            n_strobe              = 1'b1;
            n_res.released_handle = rd_hdl;
            n_res.handle_valid    = 1'b1;
            n_res.last            = i_cmd.single || (r_ready == OccW'(1));
            n_res.pending_count   = drt_pkg::CountW'(n_occ);
            n_res.ready_count     = drt_pkg::CountW'(n_ready);
        end

        // fill the freed slot from the last entry
        if (i_cmd.move) begin
            wr_hdl_en = 1'b1;
            wr_cnt_en = 1'b1;
        end

        // release-all: report slots in order, count down what remains
        if (i_cmd.all_step) begin
            if (rd_zero) begin
                n_ready = r_ready - OccW'(1);
            end
            n_idx                 = r_idx + IdxW'(1);
            n_strobe              = 1'b1;
            n_res.released_handle = rd_hdl;
            n_res.handle_valid    = 1'b1;
            n_res.last            = idx_last;
            n_res.pending_count   = drt_pkg::CountW'(r_occ - OccW'(r_idx) - OccW'(1));
            n_res.ready_count     = drt_pkg::CountW'(n_ready);
            if (idx_last) begin
                n_occ = '0;
            end
        end
    end

    // slot storage, no reset
    always_ff @(posedge i_clk) begin
        if (wr_hdl_en) begin
            r_hdl[wr_addr] <= wr_hdl;
        end
        if (wr_cnt_en) begin
            r_cnt[wr_addr] <= wr_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= '0;
            r_ready  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_occ    <= n_occ;
            r_ready  <= n_ready;
            r_strobe <= n_strobe;
        end
    end

    assign o_result = r_res;
    assign o_strobe = r_strobe;

endmodule

// File: rtl/core/deferred_release_table_top.sv
// Top level of the deferred release table: controller plus datapath.
// Depends on drt_pkg, drt_ctrl and drt_datapath.
//
// Usage:
//   An item (action, handle, frame_delay) is taken at a rising edge with
//   start high and busy low. Each result appears on o_result for exactly
//   one cycle with o_strobe high; result.last marks the final result of
//   the item. The receiver has no way to stall and must take every result.
//   Timing and throughput, per action:
//   - insert and unused codes, and any action that finds nothing to do:
//     one result the cycle after acceptance; busy stays low, so items may
//     be issued every cycle.
//   - frame tick and release-all: one slot per cycle, busy for the whole walk.
//   - release-one / release-ready: the scan reads one slot per cycle, and
//     each release is followed by a move of the last entry into the
//     freed slot; the scan then resumes at that slot.
//   The single slot read port of the datapath sets these rates.
//   Reset empties the table; slot contents are not cleared.
module deferred_release_table_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  drt_pkg::t_item   i_item,
    output logic             busy,
    output logic             o_strobe,
    output drt_pkg::t_result o_result
);

    drt_pkg::t_cmd cmd;
    drt_pkg::t_sts sts;

    drt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_item.action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    drt_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

endmodule

// File: dv/deferred_release_table_checker.sv
// Checker for the deferred release table: predicts every result of each accepted item
// and compares the results that the block strobes out against that prediction.
// Depends on drt_pkg.
`timescale 1ns / 100ps

module deferred_release_table_checker
    import drt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_item       i_item,
    input  logic        i_strobe,
    input  t_result     i_result,
    output int unsigned o_errors,
    output int unsigned o_outstanding
);

    // predicted table contents
    logic [HandleW-1:0] tbl_handle [TableDepth];
    logic [DelayW-1:0]  tbl_countdown [TableDepth];
    int unsigned        tbl_fill;

    // results predicted but not yet seen, oldest first
    t_result            due_results [$];
    int unsigned        error_count;

    // count held entries from slot first upward whose countdown is zero
    function automatic logic [CountW-1:0] ready_from(input int unsigned first);
        int unsigned n;
        n = 0;
        for (int unsigned i = first; i < tbl_fill; i++) begin
            if (tbl_countdown[i] == '0) n++;
        end
        return CountW'(n);
    endfunction

    // queue one predicted result
    function automatic void push_due(input logic [HandleW-1:0] hdl, input logic valid,
                                     input logic rej, input int unsigned pend,
                                     input logic [CountW-1:0] ready, input logic fin);
        t_result r;
        r.released_handle = hdl;
        r.handle_valid    = valid;
        r.rejected        = rej;
        r.pending_count   = CountW'(pend);
        r.ready_count     = ready;
        r.last            = fin;
        due_results = {due_results, r};
    endfunction

    // release the lowest ready slot and fill the hole with the last entry
    function automatic logic take_first_ready(output logic [HandleW-1:0] hdl);
        int unsigned tail;
        hdl = '0;
        for (int unsigned i = 0; i < tbl_fill; i++) begin
            if (tbl_countdown[i] == '0) begin
                tail = tbl_fill - 1;
                hdl  = tbl_handle[i];
                if (i != tail) begin
                    tbl_handle[i]    = tbl_handle[tail];
                    tbl_countdown[i] = tbl_countdown[tail];
                end
                tbl_fill = tail;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // update the predicted table for one item and queue its results
    function automatic void apply_table_action(input t_item it);
        logic [HandleW-1:0] hdl;
        logic [CountW-1:0]  rdy;
        int unsigned        n_out;
        int unsigned        remain;
        case (it.action)
            ACT_INSERT: begin
                if (tbl_fill < TableDepth) begin
                    tbl_handle[tbl_fill]    = it.handle;
                    tbl_countdown[tbl_fill] = it.frame_delay;
                    tbl_fill++;
                    push_due('0, 1'b0, 1'b0, tbl_fill, ready_from(0), 1'b1);
                end else begin
                    push_due('0, 1'b0, 1'b1, tbl_fill, ready_from(0), 1'b1);
                end
            end
            ACT_TICK: begin
                for (int unsigned i = 0; i < tbl_fill; i++) begin
                    if (tbl_countdown[i] != '0) tbl_countdown[i]--;
                end
                push_due('0, 1'b0, 1'b0, tbl_fill, ready_from(0), 1'b1);
            end
            ACT_RELEASE_ONE: begin
                if (take_first_ready(hdl)) begin
                    push_due(hdl, 1'b1, 1'b0, tbl_fill, ready_from(0), 1'b1);
                end else begin
                    push_due('0, 1'b0, 1'b0, tbl_fill, ready_from(0), 1'b1);
                end
            end
            ACT_RELEASE_READY: begin
                n_out = 0;
                while (n_out < TableDepth && take_first_ready(hdl)) begin
                    rdy = ready_from(0);
                    push_due(hdl, 1'b1, 1'b0, tbl_fill, rdy, rdy == '0);
                    n_out++;
                end
                if (n_out == 0) push_due('0, 1'b0, 1'b0, tbl_fill, ready_from(0), 1'b1);
            end
            ACT_RELEASE_ALL: begin
                if (tbl_fill == 0) begin
                    push_due('0, 1'b0, 1'b0, 0, '0, 1'b1);
                end else begin
                    for (int unsigned i = 0; i < tbl_fill; i++) begin
                        remain = tbl_fill - i - 1;
                        push_due(tbl_handle[i], 1'b1, 1'b0, remain, ready_from(i + 1),
                                 remain == 0);
                    end
                    tbl_fill = 0;
                end
            end
            // unused codes only report the counts
            default: push_due('0, 1'b0, 1'b0, tbl_fill, ready_from(0), 1'b1);
        endcase
    endfunction

    // compare one strobed result with the oldest prediction
    function automatic void check_result(input t_result got);
        t_result want;
        if (due_results.size() == 0) begin
            $error("result with no item outstanding: %p", got);
            error_count++;
            return;
        end
        want = due_results.pop_front();
        if (got.released_handle !== want.released_handle) begin
            $error("released_handle: expected %0h, got %0h",
                   want.released_handle, got.released_handle);
            error_count++;
        end
        if (got.handle_valid !== want.handle_valid) begin
            $error("handle_valid: expected %0d, got %0d", want.handle_valid, got.handle_valid);
            error_count++;
        end
        if (got.rejected !== want.rejected) begin
            $error("rejected: expected %0d, got %0d", want.rejected, got.rejected);
            error_count++;
        end
        if (got.pending_count !== want.pending_count) begin
            $error("pending_count: expected %0d, got %0d",
                   want.pending_count, got.pending_count);
            error_count++;
        end
        if (got.ready_count !== want.ready_count) begin
            $error("ready_count: expected %0d, got %0d", want.ready_count, got.ready_count);
            error_count++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            error_count++;
        end
    endfunction

    // check results before queuing the predictions of an item taken at the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tbl_fill = 0;
            due_results.delete();
            error_count = 0;
        end else begin
            if (i_strobe) check_result(i_result);
            if (i_start && !i_busy) apply_table_action(i_item);
        end
        o_errors      <= error_count;
        o_outstanding <= due_results.size();
    end

endmodule

// File: dv/deferred_release_table_top_tb.sv
// Testbench top for the deferred release table: clock, reset, directed and random items.
// Depends on drt_pkg, deferred_release_table_top and deferred_release_table_checker.
`timescale 1ns / 100ps

module deferred_release_table_top_tb;
    import drt_pkg::*;

    localparam logic [ActionW-1:0] ACT_LAST_CODE = '1;
    localparam int unsigned RandomItems = 435;
    localparam int unsigned QuietTail   = 60;
    localparam int unsigned DrainCycles = 3 * TableDepth + 8;
    localparam int unsigned CycleLimit  = 300000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    t_item       i_item;
    logic        busy;
    logic        o_strobe;
    t_result     o_result;
    int unsigned errors;
    int unsigned outstanding;
    int unsigned cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    deferred_release_table_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    deferred_release_table_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_item        (i_item),
        .i_strobe      (o_strobe),
        .i_result      (o_result),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    // stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("deferred_release_table_top_tb NOT OK");
            $finish;
        end
    end

    function automatic t_item make_item(input logic [ActionW-1:0] act,
                                        input logic [HandleW-1:0] hdl,
                                        input logic [DelayW-1:0] dly);
        t_item it;
        it.action      = act;
        it.handle      = hdl;
        it.frame_delay = dly;
        return it;
    endfunction

    // pick an action, favoring inserts by insert_pct; delays are mostly short
    function automatic t_item random_item(input int unsigned insert_pct);
        t_item       it;
        int unsigned sel;
        it.handle      = 16'($urandom);
        it.frame_delay = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < insert_pct) begin
            it.action = ACT_INSERT;
        end else begin
            sel = $urandom_range(0, 19);
            if (sel < 7)       it.action = ACT_TICK;
            else if (sel < 11) it.action = ACT_RELEASE_ONE;
            else if (sel < 15) it.action = ACT_RELEASE_READY;
            else if (sel < 18) it.action = ACT_RELEASE_ALL;
            else it.action = 3'($urandom_range(int'(ACT_RELEASE_ALL) + 1, int'(ACT_LAST_CODE)));
        end
        return it;
    endfunction

    // hold the item on the inputs until the block takes it
    task automatic send_item(input t_item it);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_for(input int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // drop start and wait until every predicted result has come out
    task automatic wait_results_done();
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    initial begin
        t_item       it;
        int unsigned taken;
        int unsigned insert_pct;
        logic        paused;

        start   = 1'b0;
        i_item  = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every action on an empty table, plus an unused code with all bits set
        send_item(make_item(ACT_RELEASE_ONE, '0, '0));
        send_item(make_item(ACT_RELEASE_READY, '0, '0));
        send_item(make_item(ACT_RELEASE_ALL, '0, '0));
        send_item(make_item(ACT_TICK, '0, '0));
        send_item(make_item(ACT_LAST_CODE, 16'hFFFF, 8'hFF));

        // field extremes; the tick leaves a zero countdown at zero
        send_item(make_item(ACT_INSERT, 16'hFFFF, 8'h00));
        send_item(make_item(ACT_INSERT, 16'h0000, 8'hFF));
        send_item(make_item(ACT_INSERT, 16'h1234, 8'h01));
        send_item(make_item(ACT_TICK, '0, '0));
        // release slot zero and move the last entry into it
        send_item(make_item(ACT_RELEASE_ONE, '0, '0));
        send_item(make_item(ACT_RELEASE_READY, '0, '0));

        // fill the table, overflow it, then empty it with the most results per item
        for (int i = 0; i < TableDepth - 1; i++) begin
            send_item(make_item(ACT_INSERT, 16'($urandom), 8'(i % 3)));
        end
        send_item(make_item(ACT_INSERT, 16'hA5A5, 8'h00));
        send_item(make_item(ACT_RELEASE_ALL, '0, '0));

        // random phases that alternate between filling and draining the table
        taken  = 0;
        paused = 1'b0;
        while (taken < RandomItems) begin
            insert_pct = ((taken % 60) < 30) ? 70 : 25;
            it = random_item(insert_pct);
            send_item(it);
            taken++;
            if (!paused && taken >= RandomItems / 2) begin
                wait_results_done();
                paused = 1'b1;
            end
            if (taken < RandomItems - QuietTail && ((taken / 40) % 2) == 0 &&
                $urandom_range(0, 2) == 0) begin
                idle_for($urandom_range(1, 9));
            end
        end

        wait_results_done();
        repeat (DrainCycles) @(posedge i_clk);

        if (errors == 0 && outstanding == 0) begin
            $display("deferred_release_table_top_tb OK");
        end else begin
            $display("deferred_release_table_top_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/drt_pkg.sv
rtl/core/drt_ctrl.sv
rtl/core/drt_datapath.sv
rtl/core/deferred_release_table_top.sv
dv/deferred_release_table_checker.sv
dv/deferred_release_table_top_tb.sv
